@@ hw/rtl/wti_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint trajectory interpolator package
// Shared widths, request codes, controller states and saturation helper.
// ----------------------------------------------------------------------------
package wti_pkg;

    localparam int DEF_MAX_WAYPOINTS = 1024;
    localparam int DEF_NUM_JOINTS    = 5;

    localparam int POS_W      = 16;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 16;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int QUO_W      = 16;
    localparam int PROD_W     = TIME_W + QUO_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_RESTART = 2'd2
    } req_t;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_SCAN = 12'b0000_0000_0010,
        ST_RDA  = 12'b0000_0000_0100,
        ST_RDB  = 12'b0000_0000_1000,
        ST_RDC  = 12'b0000_0001_0000,
        ST_RDD  = 12'b0000_0010_0000,
        ST_JNT  = 12'b0000_0100_0000,
        ST_MUL  = 12'b0000_1000_0000,
        ST_DVI  = 12'b0001_0000_0000,
        ST_DIV  = 12'b0010_0000_0000,
        ST_JWR  = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } state_t;

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [POS_W+2:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/waypoint_trajectory_interpolator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint trajectory interpolator
// Timed waypoint table with linear interpolation of joint commands.
// ----------------------------------------------------------------------------
// The s_ channel carries requests: s_tuser is the request kind (load, tick,
// restart). A load writes one table slot and a restart clears the running
// time; neither returns a result. A tick returns one result on the m_
// channel: the joint commands in m_tdata and the completion flag in m_tlast.
// A tick scans the valid table entries through the single memory read port,
// one entry per cycle, then reads three entries and runs each joint through
// one shared multiplier and a 16-step restoring divider; joints that need no
// interpolation skip the multiplier and the divider.
// Requests are taken one at a time. The finished result sits in an output
// register, so the next request is accepted while it waits; if the receiver
// still stalls when the following tick completes, that tick holds until the
// register frees up.
// The cfg_ channel writes offsets and the waypoint count and is always ready.
// Reset clears the running time, offsets, count and control state; the
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module waypoint_trajectory_interpolator
    import wti_pkg::*;
#(
    parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS,
    parameter int NUM_JOINTS    = DEF_NUM_JOINTS,
    localparam int IN_RAW = IDX_W + TIME_W + POS_W * NUM_JOINTS + STEP_W,
    localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_W  = POS_W * NUM_JOINTS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // entry_index, entry_time, entry_pos_0.., time_step, zero pad
    input  wire logic [IN_W-1:0]       s_tdata,
    // req_type
    input  wire logic [REQ_W-1:0]      s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // joint_cmd_0, joint_cmd_1, ..
    output logic [OUT_W-1:0]           m_tdata,
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int NW    = $clog2(MAX_WAYPOINTS + 1);
    localparam int JW    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int MEM_W = TIME_W + POS_W * NUM_JOINTS;
    localparam int POS_LSB  = IDX_W + TIME_W;
    localparam int STEP_LSB = POS_LSB + POS_W * NUM_JOINTS;

    logic [MEM_W-1:0] mem [MAX_WAYPOINTS];
    logic [MEM_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;

    state_t                  state_reg;
    logic [TIME_W-1:0]       rt_reg;
    logic signed [POS_W-1:0] offset_reg [NUM_JOINTS];
    logic [CNT_W-1:0]        count_reg;
    logic [NW-1:0]           n_reg;
    logic [TIME_W-1:0]       t_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    empty_reg;
    logic [NW-1:0]           scan_cnt_reg;
    logic                    cmp_vld_reg;
    logic [AW-1:0]           cmp_idx_reg;
    logic                    found_reg;
    logic [AW-1:0]           idx_reg;
    logic                    interp_reg;
    logic [TIME_W-1:0]       t0_reg;
    logic [TIME_W-1:0]       t1_reg;
    logic [TIME_W-1:0]       last_time_reg;
    logic [TIME_W-1:0]       el_reg;
    logic [TIME_W-1:0]       span_reg;
    logic signed [POS_W-1:0] p0_reg [NUM_JOINTS];
    logic signed [POS_W-1:0] p1_reg [NUM_JOINTS];
    logic signed [POS_W-1:0] cmd_reg [NUM_JOINTS];
    logic [JW-1:0]           j_reg;
    logic [POS_W-1:0]        absd_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [TIME_W-1:0]       rem_reg;
    logic [QUO_W-1:0]        qsh_reg;
    logic [3:0]              dcnt_reg;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic                    m_tlast_reg;

    logic                    s_acc;
    logic [NW-1:0]           n_now;
    logic [NW:0]             idx_inc;
    logic [TIME_W-1:0]       rd_time;
    logic signed [POS_W:0]   diff;
    logic [PROD_W:0]         dvd;
    logic [TIME_W:0]         trial;
    logic                    ge;
    logic signed [POS_W+2:0] posv;
    logic signed [POS_W+2:0] sumv;
    logic [TIME_W:0]         rt_sum;
    logic [TIME_W-1:0]       rt_new;
    logic                    out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign n_now    = (32'(count_reg) > 32'(MAX_WAYPOINTS)) ? NW'(MAX_WAYPOINTS)
                                                            : NW'(count_reg);
    assign idx_inc  = (NW + 1)'(idx_reg) + (NW + 1)'(1);
    assign rd_time  = rd_data_reg[TIME_W-1:0];
    assign diff     = (POS_W + 1)'(p1_reg[j_reg]) - (POS_W + 1)'(p0_reg[j_reg]);
    assign dvd      = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(span_reg >> 1);
    assign trial    = {rem_reg, qsh_reg[QUO_W-1]};
    assign ge       = (trial >= {1'b0, span_reg});
    assign rt_sum   = {1'b0, rt_reg} + (TIME_W + 1)'(step_reg);
    assign rt_new   = rt_sum[TIME_W] ? '1 : rt_sum[TIME_W-1:0];
    assign wr_en    = s_acc && (s_tuser == REQ_LOAD)
                      && (32'(s_tdata[IDX_W-1:0]) < 32'(MAX_WAYPOINTS));

    always_comb begin
        posv = (POS_W + 3)'(p0_reg[j_reg]);
        if (interp_reg) begin
            if (neg_reg) begin
                posv = posv - (POS_W + 3)'(qsh_reg);
            end else begin
                posv = posv + (POS_W + 3)'(qsh_reg);
            end
        end
        sumv = posv + (POS_W + 3)'(offset_reg[j_reg]);
    end

    always_comb begin
        rd_addr = '0;
        unique case (state_reg)
            ST_SCAN: rd_addr = scan_cnt_reg[AW-1:0];
            ST_RDA:  rd_addr = idx_reg;
            ST_RDB:  rd_addr = idx_inc[AW-1:0];
            ST_RDC:  rd_addr = AW'(n_reg - NW'(1));
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[AW'(s_tdata[IDX_W-1:0])] <= s_tdata[POS_LSB+POS_W*NUM_JOINTS-1:IDX_W];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
                offset_reg[k] <= '0;
            end
            count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (32'(cfg_index) < 32'(NUM_JOINTS)) begin
                offset_reg[cfg_index[JW-1:0]] <= cfg_data;
            end else if (32'(cfg_index) == 32'(NUM_JOINTS)) begin
                count_reg <= cfg_data[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rt_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
        end else begin
            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && (s_tuser == REQ_RESTART)) begin
                        rt_reg <= '0;
                    end else if (s_acc && (s_tuser == REQ_TICK)) begin
                        t_reg        <= rt_reg;
                        step_reg     <= s_tdata[STEP_LSB+STEP_W-1:STEP_LSB];
                        n_reg        <= n_now;
                        scan_cnt_reg <= '0;
                        cmp_vld_reg  <= 1'b0;
                        found_reg    <= 1'b0;
                        idx_reg      <= '0;
                        interp_reg   <= 1'b0;
                        j_reg        <= '0;
                        empty_reg    <= (n_now == '0);
                        if (n_now == '0) begin
                            for (int k = 0; k < NUM_JOINTS; k++) begin
                                p0_reg[k] <= '0;
                            end
                            state_reg <= ST_JNT;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (cmp_vld_reg && (rd_time <= t_reg)) begin
                        found_reg <= 1'b1;
                        idx_reg   <= cmp_idx_reg;
                    end
                    if (scan_cnt_reg < n_reg) begin
                        cmp_vld_reg  <= 1'b1;
                        cmp_idx_reg  <= scan_cnt_reg[AW-1:0];
                        scan_cnt_reg <= scan_cnt_reg + NW'(1);
                    end else begin
                        cmp_vld_reg <= 1'b0;
                        if (!cmp_vld_reg) begin
                            state_reg <= ST_RDA;
                        end
                    end
                end
                ST_RDA: begin
                    state_reg <= ST_RDB;
                end
                ST_RDB: begin
                    t0_reg <= rd_time;
                    for (int k = 0; k < NUM_JOINTS; k++) begin
                        p0_reg[k] <= rd_data_reg[TIME_W+POS_W*k +: POS_W];
                    end
                    interp_reg <= found_reg && (idx_inc < (NW + 1)'(n_reg));
                    state_reg  <= ST_RDC;
                end
                ST_RDC: begin
                    t1_reg <= rd_time;
                    for (int k = 0; k < NUM_JOINTS; k++) begin
                        p1_reg[k] <= rd_data_reg[TIME_W+POS_W*k +: POS_W];
                    end
                    state_reg <= ST_RDD;
                end
                ST_RDD: begin
                    last_time_reg <= rd_time;
                    el_reg        <= t_reg - t0_reg;
                    span_reg      <= t1_reg - t0_reg;
                    state_reg     <= ST_JNT;
                end
                ST_JNT: begin
                    neg_reg  <= diff[POS_W];
                    absd_reg <= diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
                    if (interp_reg) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_JWR;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'(el_reg) * PROD_W'(absd_reg);
                    state_reg <= ST_DVI;
                end
                ST_DVI: begin
                    rem_reg   <= dvd[PROD_W-1:QUO_W];
                    qsh_reg   <= dvd[QUO_W-1:0];
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg  <= ge ? TIME_W'(trial - {1'b0, span_reg}) : trial[TIME_W-1:0];
                    qsh_reg  <= {qsh_reg[QUO_W-2:0], ge};
                    dcnt_reg <= dcnt_reg + 4'd1;
                    if (dcnt_reg == 4'(QUO_W - 1)) begin
                        state_reg <= ST_JWR;
                    end
                end
                ST_JWR: begin
                    cmd_reg[j_reg] <= sat16(sumv);
                    if (j_reg == JW'(NUM_JOINTS - 1)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        j_reg     <= j_reg + JW'(1);
                        state_reg <= ST_JNT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        for (int k = 0; k < NUM_JOINTS; k++) begin
                            m_tdata_reg[POS_W*k +: POS_W] <= cmd_reg[k];
                        end
                        m_tlast_reg  <= empty_reg || (rt_new >= last_time_reg);
                        rt_reg       <= rt_new;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/wti_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint trajectory interpolator port checker
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module wti_checker
    import wti_pkg::*;
#(
    parameter int IN_W  = 144,
    parameter int OUT_W = 80
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_W-1:0]       s_tdata,
    input wire logic [REQ_W-1:0]      s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_W-1:0]      m_tdata,
    input wire logic                  m_tlast,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_TICK) |=> !s_tready)
        else $error("tick request did not occupy the block");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the block was idle");

endmodule

bind waypoint_trajectory_interpolator wti_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
) u_wti_checker (.*);
`default_nettype wire

@@ tb/waypoint_trajectory_interpolator_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Waypoint trajectory interpolator checker
// Watches the request, result and register channels, predicts the joint
// commands and completion flag of every tick, and compares them in order.
// ----------------------------------------------------------------------------
module waypoint_trajectory_interpolator_check
    import wti_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [143:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [79:0]  m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [3:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output int                fail_count,
    output int                pending
);

    localparam int NJ = 5;

    typedef struct packed {
        logic [NJ-1:0][15:0] cmd;
        logic                done;
    } joint_result_t;

    logic [31:0]        wp_time [1024];
    logic signed [15:0] wp_pos  [1024][NJ];
    logic [31:0]        run_time;
    logic signed [15:0] joint_offset [NJ];
    logic [10:0]        wp_count;
    joint_result_t      cmd_queue [$];

    function automatic int interp(int p0, int p1, logic [31:0] t, logic [31:0] t0,
                                  logic [31:0] t1);
        longint diff;
        longint unsigned span, el, mag, q;
        diff = longint'(p1) - longint'(p0);
        span = longint'(t1) - longint'(t0);
        el   = longint'(t) - longint'(t0);
        mag  = el * longint'(diff < 0 ? -diff : diff);
        q    = (mag + span / 2) / span;
        return diff < 0 ? p0 - int'(q) : p0 + int'(q);
    endfunction

    function automatic logic [15:0] clamp16(int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic joint_result_t predict_tick(logic [15:0] step);
        joint_result_t r;
        int n, idx, pos;
        bit found;
        logic [32:0] sum;
        n = wp_count > 1024 ? 1024 : wp_count;
        idx = 0;
        found = 0;
        for (int i = 0; i < n; i++) begin
            if (wp_time[i] <= run_time) begin
                idx = i;
                found = 1;
            end
        end
        for (int k = 0; k < NJ; k++) begin
            if (n == 0) begin
                pos = 0;
            end else if (found && idx + 1 < n) begin
                pos = interp(wp_pos[idx][k], wp_pos[idx+1][k], run_time, wp_time[idx],
                             wp_time[idx+1]);
            end else begin
                pos = wp_pos[idx][k];
            end
            r.cmd[k] = clamp16(pos + joint_offset[k]);
        end
        sum = {1'b0, run_time} + step;
        run_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        r.done = (n == 0) ? 1'b1 : (run_time >= wp_time[n-1]);
        return r;
    endfunction

    initial pending = 0;

    always @(posedge aclk) begin
        joint_result_t got, want;
        if (!aresetn) begin
            run_time = '0;
            wp_count = '0;
            for (int k = 0; k < NJ; k++) joint_offset[k] = '0;
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < NJ) joint_offset[cfg_index] = cfg_data;
                else if (cfg_index == NJ) wp_count = cfg_data[10:0];
            end
            if (s_tvalid && s_tready) begin
                case (req_t'(s_tuser))
                    REQ_LOAD: begin
                        wp_time[s_tdata[9:0]] = s_tdata[41:10];
                        for (int k = 0; k < NJ; k++)
                            wp_pos[s_tdata[9:0]][k] = s_tdata[42+16*k +: 16];
                    end
                    REQ_TICK: cmd_queue.insert(cmd_queue.size(),
                                               predict_tick(s_tdata[137:122]));
                    REQ_RESTART: run_time = '0;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.cmd = m_tdata;
                got.done = m_tlast;
                if (cmd_queue.size() == 0) begin
                    $display("%0t: result expected none actual %h", $time, got);
                    fail_count = fail_count + 1;
                end else begin
                    want = cmd_queue.pop_front();
                    for (int k = 0; k < NJ; k++) begin
                        if (got.cmd[k] !== want.cmd[k]) begin
                            $display("%0t: joint_cmd_%0d expected %0d actual %0d", $time, k,
                                     $signed(want.cmd[k]), $signed(got.cmd[k]));
                            fail_count = fail_count + 1;
                        end
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: trajectory_done expected %0b actual %0b", $time,
                                 want.done, got.done);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        pending = cmd_queue.size();
    end

endmodule

@@ tb/waypoint_trajectory_interpolator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Waypoint trajectory interpolator testbench
// Loads waypoint tables, writes offsets and counts between phases, and sends
// directed and random ticks, restarts and loads with bursty requests and a
// stalling receiver; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module waypoint_trajectory_interpolator_test;
    import wti_pkg::*;

    localparam int NJ = 5;
    localparam int IDLE_LIMIT = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [79:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [3:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;
    int           fail_count;
    int           pending;

    int  burst_left = 0;
    int  hold_cycles = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  written [1024];
    logic [31:0] next_time;

    always #4 aclk = ~aclk;

    waypoint_trajectory_interpolator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    waypoint_trajectory_interpolator_check checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    // The receiver switches at random between stall patterns and can be held stalled.
    always @(posedge aclk) begin
        int rx_cycle, rx_mode;
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
        rx_cycle++;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("waypoint_trajectory_interpolator: mismatch");
                $finish;
            end
        end
    end

    function automatic logic [15:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_request(req_t kind, logic [9:0] slot, logic [31:0] wtime,
                                logic [15:0] step);
        logic [79:0] pos;
        for (int k = 0; k < NJ; k++) pos[16*k +: 16] = rand_pos();
        if (burst_left == 0) begin
            if (s_tvalid) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'd0, step, pos, wtime, slot};
        if (kind == REQ_LOAD) written[slot] = 1;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        if (s_tvalid) s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_offsets(bit extremes);
        for (int k = 0; k < NJ; k++)
            write_reg(4'(k), extremes ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                      : 16'($urandom_range(0, 65535)));
    endtask

    task automatic load_ascending(int first, int last, int spacing, bit only_new);
        for (int i = first; i < last; i++) begin
            next_time = next_time + $urandom_range(1, spacing);
            if (!only_new || !written[i]) send_request(REQ_LOAD, 10'(i), next_time, 16'd0);
        end
    endtask

    task automatic random_phase(int n, int ops);
        int spacing;
        spacing = $urandom_range(1, 4) * 60000;
        next_time = $urandom_range(0, 100000);
        load_ascending(0, n, spacing, 0);
        send_request(REQ_RESTART, 10'd0, 32'd0, 16'd0);
        for (int j = 0; j < ops; j++) begin
            case ($urandom_range(0, 19))
                0, 1: send_request(REQ_RESTART, 10'($urandom), $urandom, 16'($urandom));
                2, 3: send_request(REQ_LOAD, 10'($urandom_range(0, n - 1)), $urandom,
                                   16'($urandom));
                4: send_request(REQ_LOAD, 10'($urandom_range(0, 1023)), $urandom,
                                16'($urandom));
                5: send_request(req_t'(2'd3), 10'($urandom), $urandom, 16'($urandom));
                default: send_request(REQ_TICK, 10'($urandom), $urandom,
                                      16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, spacing / 2)));
            endcase
        end
    endtask

    initial begin
        int phase, n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: commands equal the offsets and completion is set.
        send_request(REQ_TICK, 10'd0, 32'd0, 16'd0);
        send_request(REQ_TICK, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF);
        drain();
        write_reg(4'd0, 16'h7FFF);
        write_reg(4'd1, 16'h8000);
        write_reg(4'd2, 16'h0000);
        write_reg(4'd3, 16'hFFFF);
        write_reg(4'd4, 16'h0001);
        send_request(REQ_TICK, 10'd0, 32'd0, 16'h1234);
        // Short table with equal times, a tick before the first time and past the end.
        send_request(REQ_LOAD, 10'd0, 32'h0001_0000, 16'd0);
        send_request(REQ_LOAD, 10'd1, 32'h0002_0000, 16'd0);
        send_request(REQ_LOAD, 10'd2, 32'h0002_0000, 16'd0);
        send_request(REQ_LOAD, 10'd3, 32'h0003_0000, 16'd0);
        drain();
        write_reg(4'd5, 16'd4);
        send_request(REQ_RESTART, 10'd0, 32'd0, 16'd0);
        send_request(REQ_TICK, 10'd0, 32'd0, 16'h8000);
        send_request(REQ_TICK, 10'd0, 32'd0, 16'hC000);
        send_request(REQ_TICK, 10'd0, 32'd0, 16'h5555);
        send_request(REQ_TICK, 10'd0, 32'd0, 16'hFFFF);
        send_request(req_t'(2'd3), 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(REQ_TICK, 10'd0, 32'd0, 16'hFFFF);
        send_request(REQ_TICK, 10'd0, 32'd0, 16'h0000);
        send_request(REQ_RESTART, 10'd0, 32'd0, 16'd0);
        send_request(REQ_TICK, 10'd0, 32'd0, 16'h0001);
        drain();

        phase = 0;
        while (items_sent < 470) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            set_offsets(phase % 4 == 1);
            write_reg(4'd5, 16'(n));
            if (phase == 3) hold_cycles = 3000;
            random_phase(n, $urandom_range(20, 60));
            if (phase == 5) drain();
            drain();
            phase++;
        end

        // Full table, first with an oversized count, then at the maximum.
        next_time = 0;
        load_ascending(0, 1024, 8000, 1);
        drain();
        write_reg(4'd5, 16'd2047);
        send_request(REQ_RESTART, 10'd0, 32'd0, 16'd0);
        repeat (4) send_request(REQ_TICK, 10'd0, 32'd0, 16'($urandom_range(0, 65535)));
        drain();
        write_reg(4'd5, 16'd1024);
        set_offsets(1);
        repeat (4) send_request(REQ_TICK, 10'd0, 32'd0, 16'hFFFF);
        drain();
        repeat (1200) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("waypoint_trajectory_interpolator: match");
        end else begin
            $display("waypoint_trajectory_interpolator: mismatch");
        end
        $finish;
    end

endmodule
